### rtl/bsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

    // Default store depths and fixed curve order
    localparam int MAX_KNOTS_DEF  = 64;
    localparam int MAX_POINTS_DEF = 64;
    localparam int DEGREE         = 3;
    localparam int WFRAC          = 24;

    // APB register map (register index is paddr[2])
    localparam int   APB_AW          = 3;
    localparam logic REG_KNOT_COUNT  = 1'b0;
    localparam logic REG_POINT_COUNT = 1'b1;

    // Item commands
    localparam logic [1:0] CMD_KNOT  = 2'd0;
    localparam logic [1:0] CMD_POINT = 2'd1;
    localparam logic [1:0] CMD_EVAL  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SPAN = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_CHK,
        S_KN_RD,
        S_KN_WR,
        S_DEN,
        S_DIV,
        S_QUO,
        S_MUL_R,
        S_RND_R,
        S_UPD,
        S_WJ,
        S_PT_RD,
        S_PT_MUL,
        S_PT_ACC,
        S_FIN,
        S_OUT
    } state_t;

    // Divide by 2^s, round to nearest, ties away from zero
    function automatic logic signed [59:0] rnd_shr(input logic signed [59:0] v, input int s);
        logic [59:0] mag;
        logic [59:0] q;
        begin
            mag = v[59] ? 60'(-v) : 60'(v);
            q   = (mag + (60'(1) << (s - 1))) >> s;
            return v[59] ? -signed'(q) : signed'(q);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
        begin
            if (v > 60'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (v < -60'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [59:0] v);
        begin
            if (v > 60'sd8388607)
                return 24'sh7FFFFF;
            else if (v < -60'sd8388608)
                return 24'sh800000;
            else
                return v[23:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/bsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface bsp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [5:0]         entry_index;
    logic [15:0]        knot_value;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic signed [23:0] point_w;
    logic [23:0]        eval_time;

    modport source (output valid, cmd, entry_index, knot_value, point_x, point_y,
                    point_z, point_w, eval_time, input ready);
    modport sink   (input valid, cmd, entry_index, knot_value, point_x, point_y,
                    point_z, point_w, eval_time, output ready);
endinterface

// Result item channel
interface bsp_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] curve_x;
    logic signed [23:0] curve_y;
    logic signed [23:0] curve_z;
    logic signed [23:0] curve_w;
    logic [1:0]         eval_status;

    modport source (output valid, curve_x, curve_y, curve_z, curve_w, eval_status,
                    input ready);
    modport sink   (input valid, curve_x, curve_y, curve_z, curve_w, eval_status,
                    output ready);
endinterface

`default_nettype wire

### rtl/cubic_bspline_curve_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake        Payload
// req      in   valid / ready    cmd, entry_index, knot_value, point_x..w, eval_time
// rsp      out  valid / ready    curve_x..w, eval_status
// apb      in   psel / penable   knot_count (0x0), point_count (0x4)
//
// Load items are taken in idle and leave the block idle. An evaluate item searches
// the knots for the span, reads the six knots around it, runs six serial divisions
// with their multiplies, and multiply-accumulates the control points on the shared
// multiplier.
// Reset (rst_n, async low) clears control state; the stores are not cleared.
// A new item is taken while a finished result waits on rsp.

module cubic_bspline_curve_eval #(
    parameter int MAX_KNOTS  = bsp_pkg::MAX_KNOTS_DEF,
    parameter int MAX_POINTS = bsp_pkg::MAX_POINTS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [bsp_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    bsp_req_if.sink                        req,
    bsp_rsp_if.source                      rsp
);
    import bsp_pkg::*;

    localparam int KAW = $clog2(MAX_KNOTS);
    localparam int KCW = KAW + 1;
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int PCW = PAW + 1;
    localparam int XW  = (KCW > PCW ? KCW : PCW) + 1;

    // Configuration registers
    logic [6:0] knot_count_reg;
    logic [6:0] point_count_reg;

    // Stores
    logic [15:0] kmem [MAX_KNOTS];
    logic [95:0] pmem [MAX_POINTS];
    logic [15:0] kdata_reg;
    logic [95:0] pdata_reg;
    logic [KAW-1:0] kraddr;
    logic [PAW-1:0] praddr;

    state_t state_reg, state_next;

    logic [23:0]        t_reg;
    logic [1:0]         status_reg;
    logic [KCW-1:0]     sj_reg;
    logic [KCW-1:0]     i_reg;
    logic [2:0]         m_reg;
    logic [1:0]         j_reg;
    logic [1:0]         r_reg;
    logic [1:0]         k_reg;
    logic signed [25:0] lft_reg [1:DEGREE];
    logic signed [25:0] rgt_reg [1:DEGREE];
    logic signed [31:0] w_reg   [0:DEGREE];
    logic signed [31:0] saved_reg;
    logic signed [31:0] a_reg;
    logic               neg_reg;
    logic [15:0]        dabs_reg;
    logic [31:0]        dq_reg;
    logic [15:0]        drem_reg;
    logic [4:0]         dcnt_reg;
    logic signed [33:0] tmp_reg;
    logic signed [59:0] prod_reg;
    logic signed [59:0] acc_reg [0:3];
    logic signed [23:0] res_reg [0:3];

    logic               out_valid_reg;
    logic signed [23:0] ox_reg, oy_reg, oz_reg, ow_reg;
    logic [1:0]         ost_reg;

    // Clamped counts
    logic [KCW-1:0] kc;
    logic [PCW-1:0] pc;
    assign kc = (int'(knot_count_reg) > MAX_KNOTS) ? KCW'(MAX_KNOTS) : KCW'(knot_count_reg);
    always_comb
    begin
        if (point_count_reg == 7'd0)
            pc = PCW'(1);
        else if (int'(point_count_reg) > MAX_POINTS)
            pc = PCW'(MAX_POINTS);
        else
            pc = PCW'(point_count_reg);
    end

    // APB port
    logic wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    always_comb
    begin
        case (paddr[2])
            REG_KNOT_COUNT:  prdata = {25'd0, knot_count_reg};
            REG_POINT_COUNT: prdata = {25'd0, point_count_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg  <= 7'd0;
            point_count_reg <= 7'd1;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_KNOT_COUNT)
                knot_count_reg <= pwdata[6:0];
            else
                point_count_reg <= pwdata[6:0];
        end
    end

    // Handshakes
    logic in_acc, out_free;
    assign req.ready = (state_reg == S_IDLE);
    assign in_acc    = req.valid & req.ready;
    assign out_free  = ~out_valid_reg | rsp.ready;

    // Operand selects
    logic [1:0]         lsel, rsel;
    logic signed [25:0] lft_q, rgt_q;
    logic signed [31:0] w_q;
    logic signed [26:0] den_sum;
    logic signed [18:0] den;
    logic [18:0]        den_abs;
    logic [31:0]        w_abs;
    logic [16:0]        rem_s;
    logic               ge;
    logic signed [23:0] comp;
    logic signed [33:0] mul_a;
    logic signed [25:0] mul_b;
    logic [XW-1:0]      pidx;
    logic [KCW-1:0]     kn_addr;

    assign lsel    = j_reg - r_reg;
    assign rsel    = r_reg + 2'd1;
    assign lft_q   = lft_reg[lsel];
    assign rgt_q   = rgt_reg[rsel];
    assign w_q     = w_reg[r_reg];
    assign den_sum = 27'(rgt_q) + 27'(lft_q);
    assign den     = den_sum[26:8];
    assign den_abs = den[18] ? 19'(-den) : 19'(den);
    assign w_abs   = w_q[31] ? 32'(-w_q) : 32'(w_q);
    assign rem_s   = {drem_reg, dq_reg[31]};
    assign ge      = rem_s >= {1'b0, dabs_reg};
    assign kn_addr = i_reg - KCW'(DEGREE - 1) + KCW'(m_reg);

    always_comb
    begin
        case (k_reg)
            2'd0:    comp = pdata_reg[23:0];
            2'd1:    comp = pdata_reg[47:24];
            2'd2:    comp = pdata_reg[71:48];
            default: comp = pdata_reg[95:72];
        endcase
    end

    // Shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_MUL_R:
            begin
                mul_a = tmp_reg;
                mul_b = rgt_q;
            end
            S_RND_R:
            begin
                mul_a = tmp_reg;
                mul_b = lft_q;
            end
            default:
            begin
                mul_a = 34'(w_q);
                mul_b = 26'(comp);
            end
        endcase
    end

    // Clamped control point row
    always_comb
    begin
        pidx = XW'(i_reg) - XW'(DEGREE - 1) + XW'(r_reg);
        if (pidx > XW'(pc) - XW'(1))
            pidx = XW'(pc) - XW'(1);
    end
    assign praddr = pidx[PAW-1:0];
    assign kraddr = (state_reg == S_KN_RD) ? kn_addr[KAW-1:0] : sj_reg[KAW-1:0];

    // Stores: write on load items, registered read every cycle
    always_ff @(posedge clk)
    begin
        if (in_acc && req.cmd == CMD_KNOT && int'(req.entry_index) < MAX_KNOTS)
            kmem[KAW'(req.entry_index)] <= req.knot_value;
        kdata_reg <= kmem[kraddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && req.cmd == CMD_POINT && int'(req.entry_index) < MAX_POINTS)
            pmem[PAW'(req.entry_index)] <= {req.point_w, req.point_z, req.point_y, req.point_x};
        pdata_reg <= pmem[praddr];
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc && req.cmd == CMD_EVAL)
                    state_next = (kc < KCW'(DEGREE + 1)) ? S_OUT : S_SRCH_RD;
            S_SRCH_RD:
                state_next = S_SRCH_CMP;
            S_SRCH_CMP:
                if (kdata_reg > t_reg[23:8] || sj_reg == kc - KCW'(1))
                    state_next = S_CHK;
                else
                    state_next = S_SRCH_RD;
            S_CHK:
                if ((KCW + 1)'(i_reg) + (KCW + 1)'(DEGREE + 1) > (KCW + 1)'(kc))
                    state_next = S_OUT;
                else
                    state_next = S_KN_RD;
            S_KN_RD:
                state_next = S_KN_WR;
            S_KN_WR:
                state_next = (m_reg == 3'(2 * DEGREE - 1)) ? S_DEN : S_KN_RD;
            S_DEN:
                state_next = (den == 19'sd0) ? S_OUT : S_DIV;
            S_DIV:
                if (dcnt_reg == 5'd31)
                    state_next = S_QUO;
            S_QUO:
                state_next = S_MUL_R;
            S_MUL_R:
                state_next = S_RND_R;
            S_RND_R:
                state_next = S_UPD;
            S_UPD:
                state_next = (rsel == j_reg) ? S_WJ : S_DEN;
            S_WJ:
                state_next = (j_reg == 2'(DEGREE)) ? S_PT_RD : S_DEN;
            S_PT_RD:
                state_next = S_PT_MUL;
            S_PT_MUL:
                state_next = S_PT_ACC;
            S_PT_ACC:
                if (k_reg != 2'd3)
                    state_next = S_PT_MUL;
                else if (r_reg == 2'(DEGREE))
                    state_next = S_FIN;
                else
                    state_next = S_PT_RD;
            S_FIN:
                if (k_reg == 2'd3)
                    state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                t_reg      <= req.eval_time;
                status_reg <= (kc < KCW'(DEGREE + 1)) ? ST_SPAN : ST_OK;
                sj_reg     <= KCW'(DEGREE);
                m_reg      <= 3'd0;
                for (int n = 0; n < 4; n++)
                    acc_reg[n] <= 60'sd0;
            end
            S_SRCH_CMP:
                if (kdata_reg > t_reg[23:8])
                    i_reg <= sj_reg - KCW'(1);
                else if (sj_reg == kc - KCW'(1))
                    i_reg <= kc - KCW'(1);
                else
                    sj_reg <= sj_reg + KCW'(1);
            S_CHK:
                if ((KCW + 1)'(i_reg) + (KCW + 1)'(DEGREE + 1) > (KCW + 1)'(kc))
                    status_reg <= ST_SPAN;
            S_KN_WR:
            begin
                // knots i-2..i go to lft[3..1], i+1..i+3 to rgt[1..3]
                if (m_reg < 3'(DEGREE))
                    lft_reg[2'(3'(DEGREE) - m_reg)] <=
                        26'($signed({2'b0, t_reg})) - 26'($signed({2'b0, kdata_reg, 8'd0}));
                else
                    rgt_reg[2'(m_reg - 3'(DEGREE - 1))] <=
                        26'($signed({2'b0, kdata_reg, 8'd0})) - 26'($signed({2'b0, t_reg}));
                m_reg     <= m_reg + 3'd1;
                w_reg[0]  <= 32'sd1 <<< WFRAC;
                j_reg     <= 2'd1;
                r_reg     <= 2'd0;
                saved_reg <= 32'sd0;
            end
            S_DEN:
            begin
                if (den == 19'sd0)
                    status_reg <= ST_ZERO;
                neg_reg  <= w_q[31] ^ den[18];
                dabs_reg <= den_abs[15:0];
                dq_reg   <= w_abs + 32'(den_abs[15:1]);
                drem_reg <= 16'd0;
                dcnt_reg <= 5'd0;
            end
            S_DIV:
            begin
                drem_reg <= ge ? 16'(rem_s - {1'b0, dabs_reg}) : rem_s[15:0];
                dq_reg   <= {dq_reg[30:0], ge};
                dcnt_reg <= dcnt_reg + 5'd1;
            end
            S_QUO:
                tmp_reg <= neg_reg ? -$signed({2'b0, dq_reg}) : $signed({2'b0, dq_reg});
            S_RND_R:
                a_reg <= sat32(rnd_shr(prod_reg, 8));
            S_UPD:
            begin
                w_reg[r_reg] <= sat32(60'(saved_reg) + 60'(a_reg));
                saved_reg    <= sat32(rnd_shr(prod_reg, 8));
                r_reg        <= r_reg + 2'd1;
            end
            S_WJ:
            begin
                w_reg[j_reg] <= saved_reg;
                j_reg        <= j_reg + 2'd1;
                r_reg        <= 2'd0;
                saved_reg    <= 32'sd0;
                k_reg        <= 2'd0;
            end
            S_PT_ACC:
            begin
                acc_reg[k_reg] <= acc_reg[k_reg] + prod_reg;
                k_reg          <= k_reg + 2'd1;
                if (k_reg == 2'd3)
                    r_reg <= r_reg + 2'd1;
            end
            S_FIN:
            begin
                res_reg[k_reg] <= sat24(rnd_shr(acc_reg[k_reg], WFRAC));
                k_reg          <= k_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            ost_reg <= status_reg;
            ox_reg  <= (status_reg == ST_OK) ? res_reg[0] : 24'sd0;
            oy_reg  <= (status_reg == ST_OK) ? res_reg[1] : 24'sd0;
            oz_reg  <= (status_reg == ST_OK) ? res_reg[2] : 24'sd0;
            ow_reg  <= (status_reg == ST_OK) ? res_reg[3] : 24'sd0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.curve_x     = ox_reg;
    assign rsp.curve_y     = oy_reg;
    assign rsp.curve_z     = oz_reg;
    assign rsp.curve_w     = ow_reg;
    assign rsp.eval_status = ost_reg;

`ifndef SYNTHESIS
    // Failed evaluations give zero coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.eval_status != ST_OK |->
            rsp.curve_x == 24'sd0 && rsp.curve_y == 24'sd0 &&
            rsp.curve_z == 24'sd0 && rsp.curve_w == 24'sd0)
        else $error("nonzero coordinates with error status");

    // Load items never start the evaluation sequence
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.cmd != CMD_EVAL |=> state_reg == S_IDLE)
        else $error("load item left idle state");

    // Divider never runs on a zero divisor
    a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dabs_reg != 16'd0)
        else $error("division by zero knot span");
`endif

endmodule

`default_nettype wire
